// ===== rtl/ac3_dts_sync_header_scanner_unit_macros.svh =====
// assertion macros shared by the scanner rtl
`ifndef AC3_DTS_SYNC_HEADER_SCANNER_UNIT_MACROS_SVH
`define AC3_DTS_SYNC_HEADER_SCANNER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk_i and held off during reset
`define ADSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scanner check failed");

// next-cycle implication, clocked on clk_i and held off during reset
`define ADSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scanner check failed");

`endif

// ===== rtl/adss_pkg.sv =====
// types, constants and decode tables for the sync header scanner
package adss_pkg;

  localparam int unsigned WinLen = 10;
  localparam int unsigned FillW  = 4;

  typedef logic [WinLen-1:0][7:0] adss_window_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  stream_kind;
    logic [14:0] frame_bytes;
    logic [17:0] sample_rate_hz;
    logic [1:0]  word_format;
  } adss_result_t;

  // stream kinds
  localparam logic [2:0] KindNone = 3'd0;
  localparam logic [2:0] KindAc3  = 3'd1;
  localparam logic [2:0] KindDts1 = 3'd2;
  localparam logic [2:0] KindDts2 = 3'd3;
  localparam logic [2:0] KindDts3 = 3'd4;

  // word formats
  localparam logic [1:0] FmtBe16 = 2'd0;
  localparam logic [1:0] FmtLe16 = 2'd1;
  localparam logic [1:0] FmtBe14 = 2'd2;
  localparam logic [1:0] FmtLe14 = 2'd3;

  // ac3 header
  localparam logic [7:0] Ac3Sync0        = 8'h0B;
  localparam logic [7:0] Ac3Sync1        = 8'h77;
  localparam logic [1:0] Ac3FscodBad     = 2'd3;
  localparam logic [1:0] Ac3Fscod48k     = 2'd0;
  localparam logic [1:0] Ac3Fscod44k     = 2'd1;
  localparam logic [5:0] Ac3MaxFrmsizecod = 6'd37;
  localparam logic [4:0] Ac3MaxBsid      = 5'h11;

  // dts sync words as seen in the first four stream bytes
  localparam logic [31:0] DtsSyncBe16 = 32'h7FFE8001;
  localparam logic [31:0] DtsSyncLe16 = 32'hFE7F0180;
  localparam logic [31:0] DtsSyncBe14 = 32'h1FFFE800;
  localparam logic [31:0] DtsSyncLe14 = 32'hFF1F00E8;
  localparam logic [5:0]  DtsSyncExt14 = 6'b000001;
  localparam logic [4:0]  DtsShortFull = 5'd31;
  localparam logic [14:0] DtsMinFrame  = 15'd96;
  localparam logic [14:0] DtsMaxFrame  = 15'd16384;
  localparam logic [6:0]  DtsNblks16   = 7'd15;
  localparam logic [6:0]  DtsNblks32   = 7'd31;
  localparam logic [6:0]  DtsNblks64   = 7'd63;

  // ac3 bit rate in kbps per frmsizecod pair
  function automatic logic [9:0] ac3_kbps(input logic [4:0] idx);
    logic [9:0] k;
    unique case (idx)
      5'd0:  k = 10'd32;
      5'd1:  k = 10'd40;
      5'd2:  k = 10'd48;
      5'd3:  k = 10'd56;
      5'd4:  k = 10'd64;
      5'd5:  k = 10'd80;
      5'd6:  k = 10'd96;
      5'd7:  k = 10'd112;
      5'd8:  k = 10'd128;
      5'd9:  k = 10'd160;
      5'd10: k = 10'd192;
      5'd11: k = 10'd224;
      5'd12: k = 10'd256;
      5'd13: k = 10'd320;
      5'd14: k = 10'd384;
      5'd15: k = 10'd448;
      5'd16: k = 10'd512;
      5'd17: k = 10'd576;
      5'd18: k = 10'd640;
      default: k = 10'd0;
    endcase
    return k;
  endfunction

  // 44.1 khz word count, floor(320 * kbps / 147)
  function automatic logic [10:0] ac3_words_44k(input logic [4:0] idx);
    logic [10:0] w;
    unique case (idx)
      5'd0:  w = 11'd69;
      5'd1:  w = 11'd87;
      5'd2:  w = 11'd104;
      5'd3:  w = 11'd121;
      5'd4:  w = 11'd139;
      5'd5:  w = 11'd174;
      5'd6:  w = 11'd208;
      5'd7:  w = 11'd243;
      5'd8:  w = 11'd278;
      5'd9:  w = 11'd348;
      5'd10: w = 11'd417;
      5'd11: w = 11'd487;
      5'd12: w = 11'd557;
      5'd13: w = 11'd696;
      5'd14: w = 11'd835;
      5'd15: w = 11'd975;
      5'd16: w = 11'd1114;
      5'd17: w = 11'd1253;
      5'd18: w = 11'd1393;
      default: w = 11'd0;
    endcase
    return w;
  endfunction

  function automatic logic [17:0] ac3_rate(input logic [1:0] fscod);
    logic [17:0] r;
    unique case (fscod)
      2'd0:    r = 18'd48000;
      2'd1:    r = 18'd44100;
      2'd2:    r = 18'd32000;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

  function automatic logic [17:0] dts_rate(input logic [3:0] sfreq);
    logic [17:0] r;
    unique case (sfreq)
      4'd0:  r = 18'd0;
      4'd1:  r = 18'd8000;
      4'd2:  r = 18'd16000;
      4'd3:  r = 18'd32000;
      4'd4:  r = 18'd64000;
      4'd5:  r = 18'd128000;
      4'd6:  r = 18'd11025;
      4'd7:  r = 18'd22050;
      4'd8:  r = 18'd44100;
      4'd9:  r = 18'd88200;
      4'd10: r = 18'd176400;
      4'd11: r = 18'd12000;
      4'd12: r = 18'd24000;
      4'd13: r = 18'd48000;
      4'd14: r = 18'd96000;
      default: r = 18'd192000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/adss_ac3_check.sv =====
// ac3 sync frame header test on the byte window
module adss_ac3_check import adss_pkg::*; (
  input  adss_window_t window_i,
  output adss_result_t res_o
);

  logic [1:0]  fscod;
  logic [5:0]  code;
  logic [4:0]  bsid;
  logic [9:0]  kbps;
  logic [10:0] words_44k;
  logic [14:0] bytes;
  logic        ok;

  assign fscod     = window_i[4][7:6];
  assign code      = window_i[4][5:0];
  assign bsid      = window_i[5][7:3];
  assign kbps      = ac3_kbps(code[5:1]);
  assign words_44k = ac3_words_44k(code[5:1]);

  assign ok = (window_i[0] == Ac3Sync0) && (window_i[1] == Ac3Sync1) &&
              (fscod != Ac3FscodBad) && (code <= Ac3MaxFrmsizecod) &&
              (bsid <= Ac3MaxBsid);

  // bytes are twice the word count
  always_comb begin
    if (fscod == Ac3Fscod48k) begin
      bytes = {3'b000, kbps, 2'b00};
    end else if (fscod == Ac3Fscod44k) begin
      bytes = {3'b000, words_44k + {10'd0, code[0]}, 1'b0};
    end else begin
      bytes = {3'b000, kbps, 2'b00} + {4'b0000, kbps, 1'b0};
    end
  end

  always_comb begin
    res_o = '0;
    if (ok) begin
      res_o.hit            = 1'b1;
      res_o.stream_kind    = KindAc3;
      res_o.frame_bytes    = bytes;
      res_o.sample_rate_hz = ac3_rate(fscod);
      res_o.word_format    = FmtBe16;
    end
  end

endmodule

// ===== rtl/adss_dts_check.sv =====
// dts sync frame header test on the byte window, all four packings
module adss_dts_check import adss_pkg::*; (
  input  adss_window_t window_i,
  output adss_result_t res_o
);

  logic [31:0] sync;
  logic        le;
  logic        narrow;
  logic        sync_ok;
  logic [1:0]  fmt;
  logic [15:0] w2, w3, w4;
  logic [37:0] hdr;
  logic        ftype;
  logic [4:0]  shortc;
  logic [6:0]  nblks;
  logic [14:0] fsz;
  logic [3:0]  sfreq;
  logic [2:0]  kind;
  logic        ok;

  assign sync = {window_i[0], window_i[1], window_i[2], window_i[3]};

  always_comb begin
    sync_ok = 1'b1;
    le      = 1'b0;
    narrow  = 1'b0;
    fmt     = FmtBe16;
    if (sync == DtsSyncBe16) begin
      fmt = FmtBe16;
    end else if (sync == DtsSyncLe16) begin
      le  = 1'b1;
      fmt = FmtLe16;
    end else if (sync == DtsSyncBe14) begin
      narrow = 1'b1;
      fmt    = FmtBe14;
    end else if (sync == DtsSyncLe14) begin
      le     = 1'b1;
      narrow = 1'b1;
      fmt    = FmtLe14;
    end else begin
      sync_ok = 1'b0;
    end
  end

  // header words 2 to 4 in stream byte order
  assign w2 = le ? {window_i[5], window_i[4]} : {window_i[4], window_i[5]};
  assign w3 = le ? {window_i[7], window_i[6]} : {window_i[6], window_i[7]};
  assign w4 = le ? {window_i[9], window_i[8]} : {window_i[8], window_i[9]};

  // header bits top aligned, the 14-bit form drops the two pad bits of each word
  assign hdr = narrow ? {w2[9:0], w3[13:0], w4[13:0]} : {w2, w3, w4[15:10]};

  assign ftype  = hdr[37];
  assign shortc = hdr[36:32];
  assign nblks  = hdr[30:24];
  assign fsz    = {1'b0, hdr[23:10]} + 15'd1;
  assign sfreq  = hdr[3:0];

  always_comb begin
    case (nblks)
      DtsNblks16: kind = KindDts1;
      DtsNblks32: kind = KindDts2;
      DtsNblks64: kind = KindDts3;
      default:    kind = KindNone;
    endcase
  end

  assign ok = sync_ok && (!narrow || (w2[15:10] == DtsSyncExt14)) &&
              (sfreq != 4'd0) && !(ftype && (shortc != DtsShortFull)) &&
              (fsz >= DtsMinFrame) && (fsz <= DtsMaxFrame) && (kind != KindNone);

  always_comb begin
    res_o = '0;
    if (ok) begin
      res_o.hit            = 1'b1;
      res_o.stream_kind    = kind;
      res_o.frame_bytes    = fsz;
      res_o.sample_rate_hz = dts_rate(sfreq);
      res_o.word_format    = fmt;
    end
  end

endmodule

// ===== rtl/ac3_dts_sync_header_scanner_unit.sv =====
// top level of the ac3 / dts sync header scanner
//
// bytes of a compressed audio stream enter on the input channel, one item per
// byte; every accepted byte yields exactly one result item on the output channel
// saying whether the oldest of the last ten bytes starts an ac3 or dts frame
// header, with kind, frame length, sample rate and word format (all zero on a miss)
// path: an accepted byte is registered in the window register, which feeds the
// header tests, and its result is registered in the result register after them
// throughput: one item per cycle while the receiver does not stall, set by the path
// from the window register through the ac3 and dts tests to the result register
// stall: when the receiver stalls, the result register holds; one item may still
// sit in the window stage, and only after that does the input stall
// reset: clears the window and the fill count; the first nine results after reset
// are misses since the window is not yet full
// ac3 is tested first, dts only when the ac3 test fails
`include "ac3_dts_sync_header_scanner_unit_macros.svh"

module ac3_dts_sync_header_scanner_unit import adss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [2:0]  stream_kind_o,
  output logic [14:0] frame_bytes_o,
  output logic [17:0] sample_rate_hz_o,
  output logic [1:0]  word_format_o
);

  adss_window_t window_q, window_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic         s1_valid_q, s1_valid_d;
  logic         out_valid_q, out_valid_d;
  adss_result_t res_q, res_d;
  adss_result_t ac3_res, dts_res;
  logic         in_accept;
  logic         out_load;

  // the window stage moves on when the result register is free or draining
  assign out_load   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  // shift the new byte in at the young end, entry 0 is the oldest
  assign window_d = in_accept ? {byte_in_i, window_q[WinLen-1:1]} : window_q;
  assign fill_d   = (in_accept && (fill_q < FillW'(WinLen))) ? fill_q + FillW'(1) : fill_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  adss_ac3_check u_ac3 (
    .window_i (window_q),
    .res_o    (ac3_res)
  );

  adss_dts_check u_dts (
    .window_i (window_q),
    .res_o    (dts_res)
  );

  // no test until ten bytes are in, ac3 takes priority over dts
  always_comb begin
    res_d = '0;
    if (fill_q == FillW'(WinLen)) begin
      if (ac3_res.hit) begin
        res_d = ac3_res;
      end else if (dts_res.hit) begin
        res_d = dts_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= '0;
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      window_q    <= window_d;
      fill_q      <= fill_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only when the window stage hands over
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = res_q.hit;
  assign stream_kind_o    = res_q.stream_kind;
  assign frame_bytes_o    = res_q.frame_bytes;
  assign sample_rate_hz_o = res_q.sample_rate_hz;
  assign word_format_o    = res_q.word_format;

  `ADSS_ASSERT_IMPL(a_miss_all_zero, out_valid_q && !res_q.hit,
    (res_q.stream_kind == KindNone) && (res_q.frame_bytes == 15'd0) &&
    (res_q.sample_rate_hz == 18'd0) && (res_q.word_format == FmtBe16))
  `ADSS_ASSERT_IMPL(a_hit_has_kind, out_valid_q && res_q.hit,
    (res_q.stream_kind != KindNone) && (res_q.sample_rate_hz != 18'd0))
  `ADSS_ASSERT_NEXT(a_not_full_no_hit, out_load && (fill_q != FillW'(WinLen)),
    out_valid_q && !res_q.hit)
  `ADSS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= FillW'(WinLen))
  `ADSS_ASSERT_NEXT(a_accept_fills_stage, in_accept, s1_valid_q && (fill_q != '0))

endmodule
